// ===== src/f12cw_pkg.sv =====
package f12cw_pkg;

  localparam int DEF_TABLE_BYTES  = 512;
  localparam int DEF_SECTOR_BYTES = 512;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 3;
  localparam int POS_W      = 14;

  localparam logic [15:0] BASE_RESET = 16'd31;
  localparam logic [11:0] BAD_MARK   = 12'hFF7;
  localparam logic [11:0] END_MARK   = 12'hFF8;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [2:0] ST_MORE   = 3'd0;
  localparam logic [2:0] ST_LAST   = 3'd1;
  localparam logic [2:0] ST_BAD    = 3'd2;
  localparam logic [2:0] ST_NOFILE = 3'd3;
  localparam logic [2:0] ST_READY  = 3'd4;
  localparam logic [2:0] ST_EMPTY  = 3'd5;
  localparam logic [2:0] ST_RANGE  = 3'd6;
  localparam logic [2:0] ST_IDLE   = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  count;
    logic [16:0] sector;
  } res_t;

endpackage

// ===== src/f12cw_rem.sv =====
module f12cw_rem #(
  parameter int SECTOR_BYTES = f12cw_pkg::DEF_SECTOR_BYTES
) (
  input  logic [31:0]                           dividend,
  output logic [$clog2(SECTOR_BYTES + 1)-1:0]   rest
);

  localparam int RW = $clog2(SECTOR_BYTES + 1);
  localparam int LW = $clog2(SECTOR_BYTES);

  logic [LW-1:0] low;

  assign low  = dividend[LW-1:0];
  assign rest = (low == '0) ? RW'(SECTOR_BYTES) : RW'(low);

endmodule

// ===== src/fat12_cluster_chain_walker_unit.sv =====
// FAT12 cluster chain walker.
// Input stream: in_tuser carries the command (load table byte, start walk, step).
// Output stream: one result per start or step, none per load or unused command.
// cfg_we/cfg_wdata set the data sector base (reset 31); write only while idle.
// The allocation table sits in a single-port synchronous RAM of TABLE_BYTES bytes.
// SECTOR_BYTES is a power of two; the last-cluster byte count comes from the low
// bits of the file size, with zero taken as a full sector.
// Handling, one item at a time:
//   load: writes the byte into the table, no result.
//   start: the result goes to the output register, or is held internally while that register is full.
//   step: the block passes through RD1 and RD2; the two table bytes of an entry are read
//     from the one RAM port in consecutive cycles.
//   step while idle or with the entry past the table: result as for a start, with no table read.
// Reset clears the walk state and the base register; table contents stay
// undefined until loaded.
// A result waits in the output register while the receiver stalls; the block
// then accepts the next item, and holds a further result internally until the
// output register frees up, with in_tready low meanwhile.
module fat12_cluster_chain_walker_unit #(
  parameter int TABLE_BYTES  = f12cw_pkg::DEF_TABLE_BYTES,
  parameter int SECTOR_BYTES = f12cw_pkg::DEF_SECTOR_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // table_index[8:0], table_byte[16:9], first_cluster[28:17], file_size[60:29]
  input  logic [f12cw_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd[1:0]
  input  logic [f12cw_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // sector_number[16:0], byte_count[26:17]
  output logic [f12cw_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status[2:0]
  output logic [f12cw_pkg::OUT_USER_W-1:0]  out_tuser,
  input  logic                              cfg_we,
  input  logic [15:0]                       cfg_wdata
);
  import f12cw_pkg::*;

  localparam int AW = $clog2(TABLE_BYTES);
  localparam int RW = $clog2(SECTOR_BYTES + 1);
  localparam logic [9:0] FULL_CNT = 10'(SECTOR_BYTES);
  localparam logic [POS_W-1:0] TABLE_END = POS_W'(TABLE_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic          walk_r, walk_nxt;
  logic [11:0]   cur_r, cur_nxt;
  logic [RW-1:0] rest_r, rest_nxt;
  logic [15:0]   base_r, base_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [7:0]    lo_r, lo_nxt;
  res_t          res_r, res_nxt;
  res_t          out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [7:0]    mem [TABLE_BYTES];
  logic [7:0]    rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_ra;

  logic [1:0]       in_cmd;
  logic [8:0]       in_idx;
  logic [7:0]       in_byte;
  logic [11:0]      in_first;
  logic [31:0]      in_fsize;
  logic             in_acc;
  logic             out_free;
  logic [POS_W-1:0] pos_full;
  logic             pos_range;
  logic [11:0]      next_cl;
  logic [16:0]      sector;
  logic             emit;
  res_t             emit_res;
  logic [RW-1:0]    rem_rest;

  assign in_cmd   = in_tuser;
  assign in_idx   = in_tdata[8:0];
  assign in_byte  = in_tdata[16:9];
  assign in_first = in_tdata[28:17];
  assign in_fsize = in_tdata[60:29];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign pos_full  = POS_W'({1'b0, cur_r[11:1]}) * POS_W'(3) + POS_W'(cur_r[0]);
  assign pos_range = (pos_full + POS_W'(1)) >= TABLE_END;
  assign next_cl   = cur_r[0] ? {rdata_r, lo_r[7:4]} : {rdata_r[3:0], lo_r};
  assign sector    = 17'(cur_r) + 17'(base_r);

  f12cw_rem #(
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_rem (
    .dividend(in_fsize),
    .rest    (rem_rest)
  );

  always_comb begin
    state_nxt     = state_r;
    walk_nxt      = walk_r;
    cur_nxt       = cur_r;
    rest_nxt      = rest_r;
    base_nxt      = cfg_we ? cfg_wdata : base_r;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    emit          = 1'b0;
    emit_res      = '0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_ra        = pos_r + AW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_LOAD: begin
              mem_we = 1'b1;
            end
            CMD_START: begin
              walk_nxt = 1'b0;
              if (in_fsize == '0) begin
                emit            = 1'b1;
                emit_res.status = ST_NOFILE;
              end else if (in_first == BAD_MARK) begin
                emit            = 1'b1;
                emit_res.status = ST_BAD;
              end else if (in_first >= END_MARK) begin
                emit            = 1'b1;
                emit_res.status = ST_EMPTY;
              end else begin
                cur_nxt         = in_first;
                rest_nxt        = rem_rest;
                walk_nxt        = 1'b1;
                emit            = 1'b1;
                emit_res.status = ST_READY;
              end
            end
            CMD_STEP: begin
              if (!walk_r) begin
                emit            = 1'b1;
                emit_res.status = ST_IDLE;
              end else if (pos_range) begin
                walk_nxt        = 1'b0;
                emit            = 1'b1;
                emit_res.status = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = pos_full[AW-1:0];
                pos_nxt   = pos_full[AW-1:0];
                state_nxt = S_RD1;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD1: begin
        mem_re    = 1'b1;
        lo_nxt    = rdata_r;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        emit            = 1'b1;
        emit_res.sector = sector;
        emit_res.count  = FULL_CNT;
        if (next_cl >= END_MARK) begin
          walk_nxt        = 1'b0;
          emit_res.count  = 10'(rest_r);
          emit_res.status = ST_LAST;
        end else if (next_cl == BAD_MARK) begin
          walk_nxt        = 1'b0;
          emit_res.status = ST_BAD;
        end else begin
          cur_nxt         = next_cl;
          emit_res.status = ST_MORE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      if (out_free) begin
        out_nxt       = emit_res;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end else begin
        res_nxt   = emit_res;
        state_nxt = S_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(in_idx)] <= in_byte;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_r      <= 1'b0;
      cur_r       <= '0;
      rest_r      <= '0;
      base_r      <= BASE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      cur_r       <= cur_nxt;
      rest_r      <= rest_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r <= pos_nxt;
    lo_r  <= lo_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.count, out_r.sector};
  assign out_tuser  = out_r.status;

`ifndef ASSERT_OFF
  a_step_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_STEP && walk_r && !pos_range) |=> state_r == S_RD1 ##1
      state_r == S_RD2)
    else $error("step did not issue two table reads");

  a_walk_arm: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(walk_r) |-> $past(in_acc && in_cmd == CMD_START))
    else $error("walk armed outside a start");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("table write during entry read");

  a_more_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_MORE || out_tuser == ST_BAD) && out_tdata[16:0] != '0)
      |-> out_tdata[26:17] == FULL_CNT)
    else $error("non-last data result without full sector count");
`endif

endmodule

// ===== tb/sv/tb_fat12_cluster_chain_walker_unit.sv =====
`timescale 1ns / 1ps

module tb_fat12_cluster_chain_walker_unit;
  import f12cw_pkg::*;

  localparam int FAT_BYTES = 512;
  localparam int SECTOR_SIZE = 512;
  localparam int LAST_CLUS = 340;
  localparam int FIRST_OUT_CLUS = 341;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [IN_USER_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  logic [7:0] fat_bytes [FAT_BYTES];
  bit fat_written [FAT_BYTES];
  logic [11:0] cur_clus;
  logic [31:0] file_bytes;
  bit walking;
  logic [15:0] sector_base;
  res_t pending_reports[$];

  int mismatches = 0;
  int items_sent = 0;
  bit gaps_on;
  bit stalls_on;
  bit hold_req;

  fat12_cluster_chain_walker_unit #(
    .TABLE_BYTES(FAT_BYTES),
    .SECTOR_BYTES(SECTOR_SIZE)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int entry_pos(input logic [11:0] clus);
    return int'(clus[11:1]) * 3 + int'(clus[0]);
  endfunction

  function automatic void predict_walk(input logic [1:0] cmd, input logic [8:0] idx,
                                       input logic [7:0] tbyte, input logic [11:0] first_clus,
                                       input logic [31:0] fsize);
    res_t r;
    bit emits;
    int pos;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [11:0] nxt;
    r = '0;
    emits = 1'b1;
    case (cmd)
      CMD_LOAD: begin
        fat_bytes[idx] = tbyte;
        fat_written[idx] = 1'b1;
        emits = 1'b0;
      end
      CMD_START: begin
        walking = 1'b0;
        if (fsize == 32'd0) begin
          r.status = ST_NOFILE;
        end else if (first_clus == BAD_MARK) begin
          r.status = ST_BAD;
        end else if (first_clus >= END_MARK) begin
          r.status = ST_EMPTY;
        end else begin
          cur_clus = first_clus;
          file_bytes = fsize;
          walking = 1'b1;
          r.status = ST_READY;
        end
      end
      CMD_STEP: begin
        if (!walking) begin
          r.status = ST_IDLE;
        end else begin
          pos = entry_pos(cur_clus);
          if (pos + 1 >= FAT_BYTES) begin
            walking = 1'b0;
            r.status = ST_RANGE;
          end else begin
            lo = fat_bytes[pos];
            hi = fat_bytes[pos + 1];
            nxt = cur_clus[0] ? {hi, lo[7:4]} : {hi[3:0], lo};
            r.sector = {5'b0, cur_clus} + {1'b0, sector_base};
            r.count = 10'(SECTOR_SIZE);
            if (nxt >= END_MARK) begin
              if (file_bytes[8:0] != 9'd0) r.count = {1'b0, file_bytes[8:0]};
              walking = 1'b0;
              r.status = ST_LAST;
            end else if (nxt == BAD_MARK) begin
              walking = 1'b0;
              r.status = ST_BAD;
            end else begin
              cur_clus = nxt;
              r.status = ST_MORE;
            end
          end
        end
      end
      default: begin
        emits = 1'b0;
      end
    endcase
    if (emits) pending_reports.push_back(r);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : report_check
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer, status %0d", out_tuser));
      end else begin
        want = pending_reports.pop_front();
        if (out_tuser !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d", out_tuser, want.status));
        if (out_tdata[16:0] !== want.sector)
          flag_mismatch($sformatf("sector got %0d want %0d", out_tdata[16:0], want.sector));
        if (out_tdata[26:17] !== want.count)
          flag_mismatch($sformatf("count got %0d want %0d", out_tdata[26:17], want.count));
      end
    end
  end

  initial begin : rx_side
    int n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (stalls_on && rst_n && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [8:0] idx, input logic [7:0] tbyte,
                           input logic [11:0] first_clus, input logic [31:0] fsize);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {3'b000, fsize, first_clus, tbyte, idx};
    do @(posedge clk); while (!in_tready);
    predict_walk(cmd, idx, tbyte, first_clus, fsize);
    items_sent++;
  endtask

  task automatic load_byte(input logic [8:0] idx, input logic [7:0] tbyte);
    send_item(CMD_LOAD, idx, tbyte, 12'($urandom), $urandom);
  endtask

  task automatic start_walk(input logic [11:0] first_clus, input logic [31:0] fsize);
    send_item(CMD_START, 9'($urandom), 8'($urandom), first_clus, fsize);
  endtask

  // fill in never-loaded entry bytes first so the step reads only known table contents
  task automatic step_walk();
    int pos;
    if (walking) begin
      pos = entry_pos(cur_clus);
      if (pos + 1 < FAT_BYTES) begin
        if (!fat_written[pos]) load_byte(9'(pos), 8'($urandom));
        if (!fat_written[pos + 1]) load_byte(9'(pos + 1), 8'($urandom));
      end
    end
    send_item(CMD_STEP, 9'($urandom), 8'($urandom), 12'($urandom), $urandom);
  endtask

  // keep the neighbor entry's nibble in a shared byte
  task automatic set_entry(input logic [11:0] clus, input logic [11:0] val);
    int pos;
    logic [7:0] lo;
    logic [7:0] hi;
    pos = entry_pos(clus);
    lo = fat_written[pos] ? fat_bytes[pos] : 8'($urandom);
    hi = fat_written[pos + 1] ? fat_bytes[pos + 1] : 8'($urandom);
    if (clus[0]) begin
      lo[7:4] = val[3:0];
      hi = val[11:4];
    end else begin
      lo = val[7:0];
      hi[3:0] = val[11:8];
    end
    load_byte(9'(pos), lo);
    load_byte(9'(pos + 1), hi);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [15:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sector_base = value;
  endtask

  task automatic walk_random_chain();
    int links;
    int steps;
    logic [11:0] head;
    logic [11:0] clus;
    logic [11:0] nxt;
    logic [31:0] fsize;
    links = $urandom_range(1, 8);
    head = 12'($urandom_range(0, LAST_CLUS));
    clus = head;
    for (int k = 0; k < links; k++) begin
      if (k == links - 1) begin
        case ($urandom_range(0, 5))
          0, 1, 2: nxt = 12'($urandom_range(END_MARK, 12'hFFF));
          3: nxt = BAD_MARK;
          default: nxt = 12'($urandom_range(FIRST_OUT_CLUS, BAD_MARK - 1));
        endcase
      end else begin
        nxt = 12'($urandom_range(0, LAST_CLUS));
      end
      set_entry(clus, nxt);
      clus = nxt;
    end
    case ($urandom_range(0, 9))
      0: fsize = 32'd0;
      1, 2: fsize = $urandom << 9;
      3, 4: fsize = 32'($urandom_range(1, 1023));
      default: fsize = $urandom;
    endcase
    if ($urandom_range(0, 15) != 0) begin
      if ($urandom_range(0, 7) == 0) start_walk(12'($urandom), fsize);
      else start_walk(head, fsize);
    end
    steps = links + $urandom_range(0, 2);
    for (int k = 0; k < steps; k++) begin
      step_walk();
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: load_byte(9'($urandom), 8'($urandom));
          1: send_item(CMD_UNUSED, 9'($urandom), 8'($urandom), 12'($urandom), $urandom);
          default: start_walk(12'($urandom), $urandom);
        endcase
      end
    end
  endtask

  task automatic test_start_cases();
    start_walk(12'($urandom), 32'd0);
    start_walk(BAD_MARK, 32'd1);
    start_walk(END_MARK, 32'd100);
    start_walk(12'hFFF, 32'hFFFF_FFFF);
    step_walk();
    send_item(CMD_UNUSED, 9'h1FF, 8'hFF, 12'hFFF, 32'hFFFF_FFFF);
    start_walk(BAD_MARK - 12'd1, 32'hFFFF_FFFF);
    step_walk();
  endtask

  task automatic test_chain_cases();
    set_entry(12'd2, 12'd3);
    set_entry(12'd3, 12'd0);
    set_entry(12'd0, 12'd1);
    set_entry(12'd1, BAD_MARK);
    start_walk(12'd2, 32'd1000);
    repeat (4) step_walk();
    set_entry(12'(LAST_CLUS), 12'hFFF);
    start_walk(12'(LAST_CLUS), 32'd1024);
    step_walk();
    start_walk(12'(LAST_CLUS), 32'd1025);
    step_walk();
    start_walk(12'(FIRST_OUT_CLUS), 32'd5);
    step_walk();
  endtask

  task automatic test_base_extremes();
    write_base(16'h0000);
    repeat (3) walk_random_chain();
    write_base(16'hFFFF);
    repeat (3) walk_random_chain();
  endtask

  task automatic test_output_hold();
    for (int k = 0; k < 24; k++) set_entry(12'(100 + k), 12'(101 + k));
    set_entry(12'd124, 12'hFFF);
    hold_req = 1'b1;
    start_walk(12'd100, $urandom | 32'd1);
    repeat (26) step_walk();
    start_walk(12'd100, 32'd512);
    step_walk();
  endtask

  task automatic test_random_walks(input int target);
    int chains;
    chains = 0;
    while (items_sent < target) begin
      if (chains % 12 == 11) begin
        case ($urandom_range(0, 3))
          0: write_base(16'h0000);
          1: write_base(16'hFFFF);
          default: write_base(16'($urandom));
        endcase
      end
      gaps_on = ($urandom_range(0, 4) != 0);
      stalls_on = ($urandom_range(0, 4) != 0);
      walk_random_chain();
      chains++;
    end
  endtask

  task automatic test_steady_stream();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (8) walk_random_chain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= CMD_LOAD;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_req = 1'b0;
    cur_clus = '0;
    file_bytes = '0;
    walking = 1'b0;
    sector_base = BASE_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_start_cases();
    test_chain_cases();
    test_base_extremes();
    test_output_hold();
    test_random_walks(1550);
    test_steady_stream();
    drain_results();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
